/* rtl/lte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lte_pkg
// Shared types, constants and tint tables of the LED twinkle envelope core.
// ----------------------------------------------------------------------------
package lte_pkg;

  // LED table geometry
  localparam int NumLeds = 60;
  localparam int IdxW    = 6;

  // acceleration factor 0.015 in Q0.16
  localparam logic [9:0] AccelQ16 = 10'd983;

  // hold countdown floor
  localparam logic signed [12:0] HoldMin = -13'sd2048;

  // item operations
  localparam logic OpInit  = 1'b0;
  localparam logic OpFrame = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CfgTint = 2'd0;
  localparam logic [1:0] CfgStep = 2'd1;
  localparam logic [1:0] CfgMax  = 2'd2;

  // tint modes
  localparam logic [1:0] TintCool      = 2'd0;
  localparam logic [1:0] TintLight     = 2'd1;
  localparam logic [1:0] TintMedium    = 2'd2;
  localparam logic [1:0] TintMediumAlt = 2'd3;

  // per-LED envelope state
  typedef struct packed {
    logic [7:0]         level;
    logic [7:0]         peak;
    logic signed [11:0] hold;
    logic               rising;
  } entry_t;

  // sequencer states
  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StDecide = 7'b0000010,
    StMul    = 7'b0000100,
    StDiv    = 7'b0001000,
    StApply  = 7'b0010000,
    StTint   = 7'b0100000,
    StDone   = 7'b1000000
  } state_e;

  // green tint factor in Q0.16 (17 bits to hold 1.0)
  function automatic logic [16:0] tint_green(input logic [1:0] mode);
    logic [16:0] f;
    case (mode) inside
      TintCool:                  f = 17'd65536;
      TintLight:                 f = 17'd61291;
      TintMedium, TintMediumAlt: f = 17'd61682;
      default:                   f = 17'd65536;
    endcase
    return f;
  endfunction

  // blue tint factor in Q0.16
  function automatic logic [16:0] tint_blue(input logic [1:0] mode);
    logic [16:0] f;
    case (mode) inside
      TintCool:                  f = 17'd65536;
      TintLight:                 f = 17'd54657;
      TintMedium, TintMediumAlt: f = 17'd46006;
      default:                   f = 17'd65536;
    endcase
    return f;
  endfunction

endpackage

/* rtl/lte_state_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lte_state_mem
// Envelope state table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lte_state_mem (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [lte_pkg::IdxW-1:0] waddr_i,
  input  lte_pkg::entry_t          wdata_i,
  input  logic                     re_i,
  input  logic [lte_pkg::IdxW-1:0] raddr_i,
  output lte_pkg::entry_t          rdata_o
);

  lte_pkg::entry_t mem_q [lte_pkg::NumLeds];
  lte_pkg::entry_t rdata_q;

  // write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read one entry, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/led_twinkle_envelope_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_twinkle_envelope_core
// Per-LED twinkle envelope: rise with accelerated step, fall, hold, respawn,
// and colour each new level through a Q0.16 tint.
// ----------------------------------------------------------------------------
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+------------------
//  command  | op_i led_index_i rand_peak_i rand_hold_i      | start_i & !busy_o
//  result   | led_out_o color_written_o red/green/blue_o    | out_valid_o
//  config   | cfg_addr_i cfg_wdata_i                        | cfg_we_i
//
//  An init, an idle LED or an index beyond the table goes straight to done; a
//  falling frame that writes a colour runs the tint state; a rising one that
//  writes also runs the shared 32x18 multiplier (6 products + 2 tint products)
//  and the 9-step restoring divider on the shared compare/subtract unit. The
//  result beat stands for one cycle as busy_o drops; the next command may be
//  taken in that cycle. Reset clears only the sequencer and configuration
//  registers; the state table is undefined until an init item writes an entry.
// ----------------------------------------------------------------------------
module led_twinkle_envelope_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_addr_i,
  input  logic [7:0]               cfg_wdata_i,
  // command
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     op_i,
  input  logic [lte_pkg::IdxW-1:0] led_index_i,
  input  logic [7:0]               rand_peak_i,
  input  logic [7:0]               rand_hold_i,
  // result
  output logic                     out_valid_o,
  output logic [lte_pkg::IdxW-1:0] led_out_o,
  output logic                     color_written_o,
  output logic [7:0]               red_level_o,
  output logic [7:0]               green_level_o,
  output logic [7:0]               blue_level_o
);

  localparam logic [3:0] MulLast  = 4'd5;
  localparam logic [3:0] DivLast  = 4'd9;
  localparam logic [3:0] TintLast = 4'd1;

  // configuration registers
  logic [1:0] tint_q;
  logic [7:0] step_q;
  logic [7:0] max_q;

  // sequencer
  lte_pkg::state_e state_q, state_d;
  logic [3:0]      cnt_q, cnt_d;
  logic            out_valid_q;
  logic            accept;

  // latched command
  logic                     op_q;
  logic [lte_pkg::IdxW-1:0] idx_q;
  logic [7:0]               rp_q;
  logic [7:0]               rh_q;

  // working state
  lte_pkg::entry_t entry_q, entry_d, rd_entry;
  logic            wr_mem_q, wr_mem_d;
  logic            color_q, color_d;
  logic            in_range;

  // arithmetic registers
  logic [17:0] k_q;
  logic [31:0] sq_q;
  logic [33:0] num_q;
  logic [23:0] cube_q;
  logic [33:0] rem_q;
  logic [33:0] dsh_q;
  logic [8:0]  quo_q;
  logic        sat_q;
  logic [7:0]  green_q;
  logic [7:0]  blue_q;

  // shared units
  logic [31:0] mul_a;
  logic [17:0] mul_b;
  logic [49:0] mul_p;
  logic [33:0] cmp_a, cmp_b;
  logic        cmp_ge;

  // decide helpers
  logic signed [12:0] hold_dec;
  logic signed [11:0] hold_next;
  logic [11:0]        hold_armed;
  logic [9:0]         level_sum;
  logic [7:0]         level_rise;

  // result registers
  logic [lte_pkg::IdxW-1:0] led_out_q;
  logic                     color_out_q;
  logic [7:0]               red_out_q, green_out_q, blue_out_q;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != lte_pkg::StIdle);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_q <= lte_pkg::TintCool;
      step_q <= 8'd5;
      max_q  <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        lte_pkg::CfgTint: tint_q <= cfg_wdata_i[1:0];
        lte_pkg::CfgStep: step_q <= cfg_wdata_i;
        lte_pkg::CfgMax:  max_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // state table
  lte_state_mem u_state_mem (
    .clk_i   (clk_i),
    .we_i    ((state_q == lte_pkg::StDone) && wr_mem_q),
    .waddr_i (idx_q),
    .wdata_i (entry_q),
    .re_i    (accept),
    .raddr_i (led_index_i),
    .rdata_o (rd_entry)
  );

  assign in_range = ({1'b0, idx_q} < 7'(lte_pkg::NumLeds));

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == lte_pkg::StMul) begin
      case (cnt_q)
        4'd0: begin
          mul_a = 32'(lte_pkg::AccelQ16);
          mul_b = 18'(step_q);
        end
        4'd1: begin
          mul_a = 32'(entry_q.peak);
          mul_b = 18'(entry_q.peak);
        end
        4'd2: begin
          mul_a = 32'(sq_q[15:0]);
          mul_b = 18'(sq_q[15:0]);
        end
        4'd3: begin
          mul_a = sq_q;
          mul_b = k_q;
        end
        4'd4: begin
          mul_a = 32'(max_q);
          mul_b = 18'(max_q);
        end
        default: begin
          mul_a = 32'(cube_q[15:0]);
          mul_b = 18'(max_q);
        end
      endcase
    end else if (state_q == lte_pkg::StTint) begin
      mul_a = 32'(entry_q.level);
      mul_b = (cnt_q == 4'd0) ? 18'(lte_pkg::tint_green(tint_q))
                              : 18'(lte_pkg::tint_blue(tint_q));
    end
  end

  assign mul_p = 50'(mul_a) * 50'(mul_b);

  // shared compare unit: overflow test first, then one quotient bit per cycle
  always_comb begin
    if (cnt_q == 4'd0) begin
      cmp_a = num_q;
      cmp_b = {1'b0, cube_q, 9'b0};
    end else begin
      cmp_a = rem_q;
      cmp_b = dsh_q;
    end
  end

  assign cmp_ge = (cmp_a >= cmp_b);

  // countdown and re-arm values
  always_comb begin
    hold_dec = 13'(rd_entry.hold) - $signed({5'b0, step_q});
    if (hold_dec < lte_pkg::HoldMin) begin
      hold_next = 12'(lte_pkg::HoldMin);
    end else begin
      hold_next = hold_dec[11:0];
    end
    hold_armed = 12'(rp_q) + 12'(step_q[7:1]) + 12'(rh_q[7:1]);
  end

  // decide what the frame or init does to the entry, and pick the next state
  always_comb begin
    entry_d  = rd_entry;
    wr_mem_d = 1'b0;
    color_d  = 1'b0;
    state_d  = state_q;
    cnt_d    = '0;
    unique case (state_q)
      lte_pkg::StIdle: begin
        if (accept) begin
          state_d = lte_pkg::StDecide;
        end
      end
      lte_pkg::StDecide: begin
        state_d = lte_pkg::StDone;
        if (!in_range) begin
          entry_d = rd_entry;
        end else if (op_q == lte_pkg::OpInit) begin
          entry_d.level  = '0;
          entry_d.peak   = rp_q;
          entry_d.hold   = hold_armed;
          entry_d.rising = 1'b1;
          wr_mem_d       = 1'b1;
        end else if (rd_entry.rising) begin
          wr_mem_d = 1'b1;
          if (rd_entry.level < rd_entry.peak) begin
            color_d = 1'b1;
            state_d = lte_pkg::StMul;
          end else begin
            entry_d.rising = 1'b0;
          end
        end else begin
          wr_mem_d     = 1'b1;
          entry_d.hold = hold_next;
          if (rd_entry.level != 8'd0) begin
            entry_d.level = (rd_entry.level > step_q) ? rd_entry.level - step_q : 8'd0;
            color_d       = 1'b1;
            state_d       = lte_pkg::StTint;
          end else if (hold_next < 0) begin
            entry_d.rising = 1'b1;
            entry_d.peak   = rp_q;
            entry_d.hold   = hold_armed;
          end
        end
      end
      lte_pkg::StMul: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == MulLast) begin
          cnt_d   = '0;
          state_d = lte_pkg::StDiv;
        end
      end
      lte_pkg::StDiv: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == DivLast) begin
          cnt_d   = '0;
          state_d = lte_pkg::StApply;
        end
      end
      lte_pkg::StApply: begin
        state_d = lte_pkg::StTint;
      end
      lte_pkg::StTint: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == TintLast) begin
          cnt_d   = '0;
          state_d = lte_pkg::StDone;
        end
      end
      lte_pkg::StDone: begin
        state_d = lte_pkg::StIdle;
      end
      default: begin
        state_d = lte_pkg::StIdle;
      end
    endcase
  end

  // clamp the accelerated rise to the ceiling
  always_comb begin
    level_sum = 10'(entry_q.level) + 10'(step_q) + 10'(quo_q);
    if (sat_q || (level_sum > 10'(max_q))) begin
      level_rise = max_q;
    end else begin
      level_rise = level_sum[7:0];
    end
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lte_pkg::StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= (state_q == lte_pkg::StDone);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      idx_q <= led_index_i;
      rp_q  <= rand_peak_i;
      rh_q  <= rand_hold_i;
    end
    case (state_q)
      lte_pkg::StDecide: begin
        entry_q  <= entry_d;
        wr_mem_q <= wr_mem_d;
        color_q  <= color_d;
      end
      lte_pkg::StMul: begin
        case (cnt_q)
          4'd0:    k_q    <= mul_p[17:0];
          4'd1:    sq_q   <= mul_p[31:0];
          4'd2:    sq_q   <= mul_p[31:0];
          4'd3:    num_q  <= mul_p[49:16];
          4'd4:    cube_q <= mul_p[23:0];
          default: cube_q <= mul_p[23:0];
        endcase
      end
      lte_pkg::StDiv: begin
        if (cnt_q == 4'd0) begin
          sat_q <= cmp_ge;
          rem_q <= num_q;
          dsh_q <= {2'b0, cube_q, 8'b0};
          quo_q <= '0;
        end else begin
          if (cmp_ge) begin
            rem_q <= rem_q - dsh_q;
          end
          quo_q <= {quo_q[7:0], cmp_ge};
          dsh_q <= dsh_q >> 1;
        end
      end
      lte_pkg::StApply: begin
        entry_q.level <= level_rise;
      end
      lte_pkg::StTint: begin
        if (cnt_q == 4'd0) begin
          green_q <= mul_p[23:16];
        end else begin
          blue_q <= mul_p[23:16];
        end
      end
      lte_pkg::StDone: begin
        led_out_q   <= idx_q;
        color_out_q <= color_q;
        red_out_q   <= color_q ? entry_q.level : 8'd0;
        green_out_q <= color_q ? green_q : 8'd0;
        blue_out_q  <= color_q ? blue_q : 8'd0;
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign led_out_o       = led_out_q;
  assign color_written_o = color_out_q;
  assign red_level_o     = red_out_q;
  assign green_level_o   = green_out_q;
  assign blue_level_o    = blue_out_q;

  // result beat only as the sequencer goes back to idle
  a_beat_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy_o)
    else $error("result beat while busy");

  // an accepted command always keeps the sequencer busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("command accepted but sequencer idle");

  // a beat without a colour carries zero levels
  a_dark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !color_written_o) |->
      (red_level_o == 8'd0 && green_level_o == 8'd0 && blue_level_o == 8'd0))
    else $error("colour levels set without a colour write");

  // every beat follows the finishing state
  a_beat_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(state_q == lte_pkg::StDone))
    else $error("result beat without finishing state");

endmodule

/* bench/led_twinkle_envelope_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_twinkle_envelope_core_tb
// Self-checking bench for the twinkle envelope core. Commands come from a
// backlog, and a clocked driver issues them with random gaps. A monitor runs
// its own envelope and tint model on each accepted command and checks every
// result beat, field by field. The run starts with directed corner cases and
// then steps through several register settings with mostly well-formed
// rise/fall/respawn traffic on a few LEDs at a time.
// ----------------------------------------------------------------------------
module led_twinkle_envelope_core_tb;
  import lte_pkg::*;

  localparam int PhaseItems  = 180;
  localparam int QuietLimit  = 4000;
  localparam int SettleSlack = 30;

  // Q0.16 tint factors, red is always full scale
  localparam logic [16:0] FullQ16    = 17'd65536;
  localparam logic [16:0] GreenLight = 17'd61291;
  localparam logic [16:0] BlueLight  = 17'd54657;
  localparam logic [16:0] GreenMed   = 17'd61682;
  localparam logic [16:0] BlueMed    = 17'd46006;

  typedef struct packed {
    logic            op;
    logic [IdxW-1:0] idx;
    logic [7:0]      peak_draw;
    logic [7:0]      hold_draw;
  } frame_cmd_t;

  typedef struct packed {
    logic [IdxW-1:0] led;
    logic            wrote;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
  } led_colour_t;

  logic            clk_i           = 1'b0;
  logic            rst_ni          = 1'b0;
  logic            cfg_we_i        = 1'b0;
  logic [1:0]      cfg_addr_i      = '0;
  logic [7:0]      cfg_wdata_i     = '0;
  logic            start_i         = 1'b0;
  logic            busy_o;
  logic            op_i            = 1'b0;
  logic [IdxW-1:0] led_index_i     = '0;
  logic [7:0]      rand_peak_i     = '0;
  logic [7:0]      rand_hold_i     = '0;
  logic            out_valid_o;
  logic [IdxW-1:0] led_out_o;
  logic            color_written_o;
  logic [7:0]      red_level_o;
  logic [7:0]      green_level_o;
  logic [7:0]      blue_level_o;

  led_twinkle_envelope_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .op_i            (op_i),
    .led_index_i     (led_index_i),
    .rand_peak_i     (rand_peak_i),
    .rand_hold_i     (rand_hold_i),
    .out_valid_o     (out_valid_o),
    .led_out_o       (led_out_o),
    .color_written_o (color_written_o),
    .red_level_o     (red_level_o),
    .green_level_o   (green_level_o),
    .blue_level_o    (blue_level_o)
  );

  // bench-side copy of the registers
  logic [1:0] cfg_tint    = TintCool;
  logic [7:0] cfg_step    = 8'd5;
  logic [7:0] cfg_ceiling = 8'd255;

  // bench-side copy of the envelope table
  logic [7:0] env_level  [64];
  logic [7:0] env_peak   [64];
  int         env_hold   [64];
  logic       env_rising [64];

  frame_cmd_t  cmd_backlog [$];
  led_colour_t colour_due  [$];
  bit          armed [64];
  int          focus_led [3];

  int idle_pct      = 0;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int beats_taken   = 0;
  int beats_checked = 0;
  int colours_seen  = 0;
  int settings_run  = 1;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // hold countdown armed by an init or a respawn
  function automatic int armed_hold(input logic [7:0] peak, input logic [7:0] draw);
    int total;
    total = peak;
    total += cfg_step >> 1;
    total += draw >> 1;
    return total;
  endfunction

  // advance one LED envelope and colour the new level
  function automatic led_colour_t advance_envelope(input frame_cmd_t c);
    led_colour_t res;
    logic [63:0] gain, peak64, ceil64, accel, total;
    logic [16:0] g_f, b_f;
    logic [24:0] wide;
    int          stride, h;
    res = '0;
    res.led = c.idx;
    stride = cfg_step;
    if (c.idx < NumLeds) begin
      if (c.op == OpInit) begin
        env_level[c.idx]  = 8'd0;
        env_peak[c.idx]   = c.peak_draw;
        env_hold[c.idx]   = armed_hold(c.peak_draw, c.hold_draw);
        env_rising[c.idx] = 1'b1;
      end else if (env_rising[c.idx]) begin
        if (env_level[c.idx] < env_peak[c.idx]) begin
          gain   = AccelQ16;
          peak64 = env_peak[c.idx];
          ceil64 = cfg_ceiling;
          accel  = 64'd0;
          if (ceil64 != 64'd0)
            accel = (gain * cfg_step * peak64 * peak64 * peak64 * peak64) /
                    (ceil64 * ceil64 * ceil64 * 64'd65536);
          total = env_level[c.idx] + cfg_step + accel;
          if (total > ceil64) total = ceil64;
          env_level[c.idx] = total[7:0];
          res.wrote = 1'b1;
        end else begin
          env_rising[c.idx] = 1'b0;
        end
      end else begin
        h = env_hold[c.idx] - stride;
        if (h < HoldMin) h = HoldMin;
        env_hold[c.idx] = h;
        if (env_level[c.idx] > 8'd0) begin
          env_level[c.idx] = (env_level[c.idx] > cfg_step) ? env_level[c.idx] - cfg_step : 8'd0;
          res.wrote = 1'b1;
        end else if (h < 0) begin
          env_rising[c.idx] = 1'b1;
          env_peak[c.idx]   = c.peak_draw;
          env_hold[c.idx]   = armed_hold(c.peak_draw, c.hold_draw);
        end
      end
    end
    if (res.wrote) begin
      case (cfg_tint)
        TintCool: begin
          g_f = FullQ16;
          b_f = FullQ16;
        end
        TintLight: begin
          g_f = GreenLight;
          b_f = BlueLight;
        end
        default: begin
          g_f = GreenMed;
          b_f = BlueMed;
        end
      endcase
      res.red   = env_level[c.idx];
      wide      = env_level[c.idx] * g_f;
      res.green = wide[23:16];
      wide      = env_level[c.idx] * b_f;
      res.blue  = wide[23:16];
    end
    return res;
  endfunction

  function automatic int field_differs(input string tag, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
      return 1;
    end
    return 0;
  endfunction

  // random draw, mostly below the ceiling
  function automatic logic [7:0] draw_value();
    logic [31:0] v;
    if (cfg_ceiling != 8'd0 && $urandom_range(9) != 0)
      v = $urandom_range(cfg_ceiling - 8'd1);
    else
      v = $urandom_range(255);
    return v[7:0];
  endfunction

  // command driver: hold a beat until it is taken, idle at random between beats
  always @(posedge clk_i) begin : drive_cmd
    frame_cmd_t nxt;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || !busy_o) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = cmd_backlog.pop_front();
        start_i     <= 1'b1;
        op_i        <= nxt.op;
        led_index_i <= nxt.idx;
        rand_peak_i <= nxt.peak_draw;
        rand_hold_i <= nxt.hold_draw;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: check result beats, then predict for the command taken
  always @(posedge clk_i) begin : watch_beats
    led_colour_t want;
    frame_cmd_t  taken;
    if (rst_ni) begin
      if (out_valid_o) begin
        if (colour_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got LED %0d", $time, led_out_o);
          mismatches++;
        end else begin
          want = colour_due.pop_front();
          mismatches += field_differs("led_out", want.led, led_out_o);
          mismatches += field_differs("color_written", want.wrote, color_written_o);
          mismatches += field_differs("red_level", want.red, red_level_o);
          mismatches += field_differs("green_level", want.green, green_level_o);
          mismatches += field_differs("blue_level", want.blue, blue_level_o);
          beats_checked++;
          if (want.wrote) colours_seen++;
        end
      end
      if (start_i && !busy_o) begin
        taken.op        = op_i;
        taken.idx       = led_index_i;
        taken.peak_draw = rand_peak_i;
        taken.hold_draw = rand_hold_i;
        colour_due.push_back(advance_envelope(taken));
        beats_taken++;
      end
      if (out_valid_o || (start_i && !busy_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // watchdog on stalled traffic
  always @(negedge clk_i) begin : watchdog
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgTint: cfg_tint    = val[1:0];
      CfgStep: cfg_step    = val;
      CfgMax:  cfg_ceiling = val;
      default: ;
    endcase
  endtask

  task automatic queue_cmd(input logic op, input logic [IdxW-1:0] idx,
                           input logic [7:0] pk, input logic [7:0] hd);
    frame_cmd_t c;
    c.op        = op;
    c.idx       = idx;
    c.peak_draw = pk;
    c.hold_draw = hd;
    cmd_backlog.push_back(c);
    if (op == OpInit && idx < NumLeds) armed[idx] = 1'b1;
  endtask

  // wait until the backlog is sent and every result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    while (cmd_backlog.size() != 0 || start_i || colour_due.size() != 0)
      @(negedge clk_i);
  endtask

  // mostly frames on the focus LEDs, with stray inits and out-of-range noise
  task automatic fill_random(input int quota);
    int placed, roll, pick;
    bit counted;
    placed = 0;
    while (placed < quota) begin
      roll    = $urandom_range(99);
      counted = 1'b1;
      if (roll < 70) begin
        queue_cmd(OpFrame, focus_led[$urandom_range(2)], draw_value(), draw_value());
      end else if (roll < 85) begin
        pick = $urandom_range(NumLeds - 1);
        queue_cmd(armed[pick] ? OpFrame : OpInit, pick, draw_value(), draw_value());
      end else if (roll < 92) begin
        queue_cmd(OpInit, $urandom_range(NumLeds - 1), draw_value(), draw_value());
      end else if (roll < 96) begin
        queue_cmd($urandom_range(1), $urandom_range(63, NumLeds),
                  $urandom_range(255), $urandom_range(255));
        counted = 1'b0;
      end else begin
        queue_cmd(OpInit, focus_led[$urandom_range(2)], draw_value(), draw_value());
      end
      if (counted) placed++;
    end
  endtask

  initial begin : stimulus
    logic [1:0] tint;
    logic [7:0] step, ceiling;
    int         idle;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corners at reset settings
    queue_cmd(OpInit,  6'd0,  8'd254, 8'd254);
    queue_cmd(OpInit,  6'd59, 8'd0,   8'd0);
    queue_cmd(OpFrame, 6'd59, 8'd0,   8'd0);    // zero peak: turn to falling at once
    queue_cmd(OpFrame, 6'd59, 8'd255, 8'd255);  // dark, hold runs out: respawn at full
    queue_cmd(OpFrame, 6'd59, 8'd0,   8'd0);    // steepest climb
    repeat (3) queue_cmd(OpFrame, 6'd0, 8'd17, 8'd34);
    queue_cmd(OpInit,  6'd60, 8'd170, 8'd85);   // beyond the table
    queue_cmd(OpFrame, 6'd63, 8'd85,  8'd170);
    queue_cmd(OpInit,  6'd1,  8'd3,   8'd200);
    repeat (4) queue_cmd(OpFrame, 6'd1, 8'd9, 8'd9);  // overshoot, turn, fall, dark
    queue_cmd(OpInit,  6'd32, 8'd128, 8'd1);
    queue_cmd(OpInit,  6'd31, 8'd127, 8'd2);
    queue_cmd(OpFrame, 6'd32, 8'd0,   8'd0);
    queue_cmd(OpFrame, 6'd31, 8'd0,   8'd0);
    queue_cmd(OpInit,  6'd0,  8'd1,   8'd0);    // re-init mid envelope
    queue_cmd(OpFrame, 6'd0,  8'd0,   8'd0);
    wait_drained();

    // random phases over several register settings and sender idle rates
    for (int k = 0; k < 8; k++) begin
      case (k)
        0:       begin tint = TintCool;      step = 8'd5;   ceiling = 8'd255; idle = 0;  end
        1:       begin tint = TintLight;     step = 8'd1;   ceiling = 8'd255; idle = 77; end
        2:       begin tint = TintMedium;    step = 8'd255; ceiling = 8'd255; idle = 16; end
        3:       begin tint = TintMediumAlt; step = 8'd37;  ceiling = 8'd100; idle = 0;  end
        4:       begin tint = TintCool;      step = 8'd200; ceiling = 8'd1;   idle = 77; end
        5:       begin tint = TintLight;     step = 8'd9;   ceiling = 8'd0;   idle = 16; end
        6:       begin tint = TintMedium;    step = 8'd20;  ceiling = 8'd180; idle = 0;  end
        default: begin tint = TintMediumAlt; step = 8'd64;  ceiling = 8'd255; idle = 77; end
      endcase
      write_reg(CfgTint, {6'd0, tint});
      write_reg(CfgStep, step);
      write_reg(CfgMax, ceiling);
      @(negedge clk_i);
      idle_pct = idle;
      for (int j = 0; j < 3; j++) begin
        focus_led[j] = $urandom_range(NumLeds - 1);
        queue_cmd(OpInit, focus_led[j], draw_value(), draw_value());
      end
      // sender holds off halfway until the core has drained
      fill_random(PhaseItems / 2);
      wait_drained();
      fill_random(PhaseItems - PhaseItems / 2);
      wait_drained();
      settings_run++;
    end

    repeat (SettleSlack) @(posedge clk_i);
    $display("Sent %0d commands over %0d register settings, sender idle 0/16/77 percent.",
             beats_taken, settings_run);
    $display("Checked %0d result beats, %0d of them carrying a new colour.",
             beats_checked, colours_seen);
    if (mismatches == 0 && colour_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
rtl/lte_pkg.sv
rtl/lte_state_mem.sv
rtl/led_twinkle_envelope_core.sv
bench/led_twinkle_envelope_core_tb.sv
